// ===== rtl/sitda_pkg.sv =====
package sitda_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CharW = 8;
  localparam int unsigned DigitW = 4;

  // A 32-bit magnitude has at most ten decimal digits.
  localparam int unsigned MaxDigits = 10;
  localparam int unsigned CntW = $clog2(MaxDigits);

  localparam logic [CharW-1:0] AsciiZero = 8'd48;
  localparam logic [CharW-1:0] AsciiMinus = 8'd45;

  // floor(x / 10) == (x * 0xCCCCCCCD) >> 35 for every 32-bit x.
  localparam logic [ValueW-1:0] Recip10 = 32'hCCCC_CCCD;
  localparam int unsigned RecipShift = 35;
  localparam int unsigned QuoW = 2 * ValueW - RecipShift;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic emit_sign;
    logic emit_digit;
  } sitda_cmd_t;

  typedef struct packed {
    logic div_done;
    logic neg;
    logic out_free;
    logic idx_zero;
  } sitda_status_t;

endpackage

// ===== rtl/sitda_ctrl.sv =====
module sitda_ctrl
  import sitda_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sitda_status_t status_i,
  output sitda_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMul  = 5'b00010,
    StDiv  = 5'b00100,
    StSign = 5'b01000,
    StEmit = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StDiv;
      end
      StDiv: begin
        cmd_o.div = 1'b1;
        if (status_i.div_done) begin
          state_d = status_i.neg ? StSign : StEmit;
        end else begin
          state_d = StMul;
        end
      end
      StSign: begin
        if (status_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = StEmit;
        end
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (status_i.idx_zero) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/sitda_datapath.sv =====
module sitda_datapath
  import sitda_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [ValueW-1:0]  value_i,
  input  sitda_cmd_t         cmd_i,
  output sitda_status_t      status_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CharW-1:0]   character_o,
  output logic               last_o
);

  logic [ValueW-1:0]   mag_q;
  logic                neg_q;
  logic [QuoW-1:0]     quo_q;
  logic [DigitW-1:0]   dig_q [MaxDigits];
  logic [CntW-1:0]     ndig_q;
  logic [CntW-1:0]     idx_q;
  logic                out_valid_q;
  logic [CharW-1:0]    char_q;
  logic                last_q;

  logic [ValueW-1:0]   in_mag;
  logic [2*ValueW-1:0] product;
  logic [ValueW-1:0]   quo_ext;
  logic [ValueW-1:0]   quo_times10;
  logic [ValueW-1:0]   rem;

  // Two's complement negate keeps the most negative value exact as unsigned.
  assign in_mag = value_i[ValueW-1] ? (~value_i + ValueW'(1)) : value_i;

  // The quotient by ten comes from a reciprocal multiply; the remainder is
  // what is left after subtracting ten times the quotient.
  assign product     = (2*ValueW)'(mag_q) * (2*ValueW)'(Recip10);
  assign quo_ext     = ValueW'(quo_q);
  assign quo_times10 = (quo_ext << 3) + (quo_ext << 1);
  assign rem         = mag_q - quo_times10;

  assign status_o.div_done = (quo_q == '0) || (ndig_q == CntW'(MaxDigits - 1));
  assign status_o.neg      = neg_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.idx_zero = (idx_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= in_mag;
      neg_q <= value_i[ValueW-1];
    end else if (cmd_i.div) begin
      mag_q <= quo_ext;
    end
    if (cmd_i.mul) begin
      quo_q <= product[RecipShift +: QuoW];
    end
    if (cmd_i.div) begin
      dig_q[ndig_q] <= rem[DigitW-1:0];
    end
    if (cmd_i.emit_sign) begin
      char_q <= AsciiMinus;
      last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      char_q <= AsciiZero + CharW'(dig_q[idx_q]);
      last_q <= (idx_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ndig_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        ndig_q <= '0;
      end else if (cmd_i.div) begin
        ndig_q <= ndig_q + CntW'(1);
        idx_q  <= ndig_q;
      end else if (cmd_i.emit_digit) begin
        idx_q <= idx_q - CntW'(1);
      end
      if (cmd_i.emit_sign || cmd_i.emit_digit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  a_ndig_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ndig_q <= CntW'(MaxDigits))
    else $error("digit count beyond ten");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_digit |-> (idx_q < ndig_q))
    else $error("digit index outside the stored digits");

  a_sign_only_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_sign |-> neg_q)
    else $error("minus sign emitted for a non-negative value");

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((char_q == AsciiMinus && !last_q) ||
                     (char_q >= AsciiZero && char_q <= AsciiZero + CharW'(9))))
    else $error("output character is neither a minus sign nor a digit");

endmodule

// ===== rtl/signed_int_to_decimal_ascii_core.sv =====
// Channel  Direction  Handshake                  Payload
// input    in         in_valid_i / in_ready_o    value_i[31:0] (signed)
// output   out        out_valid_o / out_ready_i  character_o[7:0], last_o
//
// One input beat yields one to eleven output beats, the last one flagged.
// Conversion runs a reciprocal multiply and then a remainder step for each
// decimal digit, and then emits the sign, if any, and the digits.
// Reset is asynchronous and active low; it clears the controller and the
// output valid. A stalled output holds the converter until the beat drains.
module signed_int_to_decimal_ascii_core
  import sitda_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [ValueW-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [CharW-1:0]         character_o,
  output logic                     last_o
);

  // The controller sequences the conversion and emission phases; the
  // datapath holds the magnitude, the digit store and the output register.
  sitda_cmd_t    cmd;
  sitda_status_t status;

  sitda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Digits are produced least significant first and stored, then read back
  // most significant first. The output register lets the next input beat be
  // taken while the final character still waits downstream.
  sitda_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (ValueW'(value_i)),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule
